>>> sv/pairwise_coulomb_force_sum_defines.svh
// Assertion macros for the Coulomb kick block.
// Each macro expects clk and rst_n in scope.
`ifndef PAIRWISE_COULOMB_FORCE_SUM_DEFINES_SVH
`define PAIRWISE_COULOMB_FORCE_SUM_DEFINES_SVH

`ifndef SYNTHESIS
`define PCFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PCFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCFS_ASSERT_IMP(lbl, ante, cons, msg)
`define PCFS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/pcfs_pkg.sv
package pcfs_pkg;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_GAIN  = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;

  // serial unit widths
  localparam int MUL_AW = 68;
  localparam int MUL_BW = 34;
  localparam int MUL_PW = 102;
  localparam int NUM_W  = 112;
  localparam int ACC_W  = 128;
  localparam int GQ_W   = 47;

  localparam logic [6:0] MUL_STEPS  = 7'd34;
  localparam logic [6:0] SQRT_STEPS = 7'd34;
  localparam logic [6:0] DIV_STEPS  = 7'd112;

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic              cmd;
    logic [5:0]        particle_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [7:0]  charge;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [63:0] kick_x;
    logic signed [63:0] kick_y;
    logic signed [63:0] kick_z;
    logic               coincident;
    logic               saturated;
    logic               is_last;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [7:0]  q;
  } particle_t;

  typedef enum logic [1:0] {
    SEL_SQ    = 2'd0,
    SEL_CUBE1 = 2'd1,
    SEL_CUBE2 = 2'd2,
    SEL_NUM   = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     mem_we;
    logic     rd;
    logic     diff;
    logic     mul_load;
    logic     mul_step;
    mul_sel_t mul_sel;
    logic     sum;
    logic     sqrt_load;
    logic     sqrt_step;
    logic     div_load;
    logic     div_step;
    logic     acc_clr;
    logic     acc_add;
    logic     fin_shift;
    logic     emit;
    logic     is_last;
  } cmd_t;

  typedef struct packed {
    logic s_zero;
  } stat_t;

  function automatic logic signed [31:0] axis_pos(input particle_t p, input int m);
    logic signed [31:0] v;
    v = p.z;
    if (m == 0) v = p.x;
    else if (m == 1) v = p.y;
    return v;
  endfunction

endpackage

>>> sv/pcfs_mul.sv
// shift-add multiplier, one bit of b per step
module pcfs_mul (
  input  logic                           clk,
  input  logic                           load,
  input  logic                           step,
  input  logic [pcfs_pkg::MUL_AW-1:0]    a_in,
  input  logic [pcfs_pkg::MUL_BW-1:0]    b_in,
  output logic [pcfs_pkg::MUL_PW-1:0]    prod
);

  logic [pcfs_pkg::MUL_PW-1:0] a_r, p_r;
  logic [pcfs_pkg::MUL_BW-1:0] b_r;

  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= pcfs_pkg::MUL_PW'(a_in);
      b_r <= b_in;
      p_r <= '0;
    end else if (step) begin
      if (b_r[0]) p_r <= p_r + a_r;
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign prod = p_r;

endmodule

>>> sv/pcfs_div.sv
// restoring divider, one quotient bit per step; quotient replaces numerator
module pcfs_div (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [pcfs_pkg::NUM_W-1:0]  num_in,
  input  logic [pcfs_pkg::MUL_PW-1:0] den_in,
  output logic [pcfs_pkg::NUM_W-1:0]  quo
);

  logic [pcfs_pkg::NUM_W-1:0]  n_r;
  logic [pcfs_pkg::MUL_PW-1:0] d_r, rem_r;
  logic [pcfs_pkg::MUL_PW:0]   rem2, diff;
  logic                        ge;

  always_comb begin
    rem2 = {rem_r, n_r[pcfs_pkg::NUM_W-1]};
    diff = rem2 - {1'b0, d_r};
    ge   = (rem2 >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      n_r   <= num_in;
      d_r   <= den_in;
      rem_r <= '0;
    end else if (step) begin
      rem_r <= ge ? diff[pcfs_pkg::MUL_PW-1:0] : rem2[pcfs_pkg::MUL_PW-1:0];
      n_r   <= {n_r[pcfs_pkg::NUM_W-2:0], ge};
    end
  end

  assign quo = n_r;

endmodule

>>> sv/pcfs_dp.sv
module pcfs_dp #(
  parameter int MAX_PARTICLES = 64,
  parameter int AW            = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pcfs_pkg::in_beat_t in_data,
  input  pcfs_pkg::cmd_t     cmd,
  input  logic [AW-1:0]      idx_i,
  input  logic [AW-1:0]      idx_j,
  input  logic [31:0]        cfg_gain,
  input  logic [5:0]         cfg_shift,
  output pcfs_pkg::stat_t    stat,
  output logic               out_valid,
  output pcfs_pkg::out_beat_t out_data
);

  pcfs_pkg::particle_t mem [MAX_PARTICLES];
  pcfs_pkg::particle_t rd_i_r, rd_j_r;

  logic [32:0]        absd_r [3];
  logic               dneg_r [3];
  logic               neg_r [3];
  logic signed [15:0] qq_r;
  logic [14:0]        qabs;
  logic [pcfs_pkg::GQ_W-1:0] gq_r;
  logic [65:0]        s_r;
  logic               coinc_r;

  logic [67:0] rad_r;
  logic [36:0] rem_r, rem2, trial;
  logic [33:0] root_r;

  logic [pcfs_pkg::MUL_PW-1:0] cube_r;
  logic [pcfs_pkg::MUL_AW-1:0] ma [3];
  logic [pcfs_pkg::MUL_BW-1:0] mb [3];
  logic [pcfs_pkg::MUL_PW-1:0] mp [3];
  logic [pcfs_pkg::NUM_W-1:0]  dq [3];
  logic [65:0]                 s_sum;

  logic [pcfs_pkg::ACC_W-1:0] acc_r [3];
  logic [63:0]                kick [3];
  logic                       sat [3];

  pcfs_pkg::out_beat_t out_r;
  logic                out_valid_r;

  // particle store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[in_data.particle_index[AW-1:0]] <= '{x: in_data.pos_x, y: in_data.pos_y,
                                               z: in_data.pos_z, q: in_data.charge};
    end
    if (cmd.rd) begin
      rd_i_r <= mem[idx_i];
      rd_j_r <= mem[idx_j];
    end
  end

  // multiplier lanes and dividers, one per axis
  for (genvar m = 0; m < 3; m++) begin : g_lane
    always_comb begin
      unique case (cmd.mul_sel)
        pcfs_pkg::SEL_SQ: begin
          ma[m] = pcfs_pkg::MUL_AW'(absd_r[m]);
          mb[m] = {1'b0, absd_r[m]};
        end
        pcfs_pkg::SEL_CUBE1: begin
          ma[m] = pcfs_pkg::MUL_AW'(root_r);
          mb[m] = root_r;
        end
        pcfs_pkg::SEL_CUBE2: begin
          ma[m] = mp[m][pcfs_pkg::MUL_AW-1:0];
          mb[m] = root_r;
        end
        default: begin
          ma[m] = pcfs_pkg::MUL_AW'(gq_r);
          mb[m] = {1'b0, absd_r[m]};
        end
      endcase
    end

    pcfs_mul u_mul (
      .clk  (clk),
      .load (cmd.mul_load),
      .step (cmd.mul_step),
      .a_in (ma[m]),
      .b_in (mb[m]),
      .prod (mp[m])
    );

    pcfs_div u_div (
      .clk    (clk),
      .load   (cmd.div_load),
      .step   (cmd.div_step),
      .num_in ({mp[m][79:0], 32'b0}),
      .den_in (cube_r),
      .quo    (dq[m])
    );

    always_comb begin
      sat[m]  = !((&acc_r[m][127:63]) || !(|acc_r[m][127:63]));
      kick[m] = sat[m] ? (acc_r[m][127] ? pcfs_pkg::SAT_MIN : pcfs_pkg::SAT_MAX)
                       : acc_r[m][63:0];
    end

    always_ff @(posedge clk) begin
      logic signed [32:0] d;
      d = 33'(pcfs_pkg::axis_pos(rd_i_r, m)) - 33'(pcfs_pkg::axis_pos(rd_j_r, m));
      if (cmd.diff) begin
        absd_r[m] <= d[32] ? 33'(-d) : 33'(d);
        dneg_r[m] <= d[32];
      end
      if (cmd.sum) neg_r[m] <= qq_r[15] ^ dneg_r[m];
      if (cmd.acc_clr) acc_r[m] <= '0;
      else if (cmd.acc_add) begin
        acc_r[m] <= neg_r[m] ? acc_r[m] - pcfs_pkg::ACC_W'(dq[m])
                             : acc_r[m] + pcfs_pkg::ACC_W'(dq[m]);
      end else if (cmd.fin_shift) begin
        acc_r[m] <= pcfs_pkg::ACC_W'($signed(acc_r[m]) >>> cfg_shift);
      end
    end
  end

  assign s_sum = mp[0][65:0] + mp[1][65:0] + mp[2][65:0];
  assign qabs  = qq_r[15] ? 15'(-qq_r) : qq_r[14:0];

  // digit-by-digit square root, two radicand bits a step
  assign rem2  = {rem_r[34:0], rad_r[67:66]};
  assign trial = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.diff) qq_r <= $signed(rd_i_r.q) * $signed(rd_j_r.q);
    if (cmd.sum) begin
      s_r  <= s_sum;
      gq_r <= pcfs_pkg::GQ_W'(cfg_gain) * pcfs_pkg::GQ_W'(qabs);
    end
    if (cmd.sqrt_load) begin
      rad_r  <= {2'b00, s_r};
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= rad_r << 2;
      if (rem2 >= trial) begin
        rem_r  <= rem2 - trial;
        root_r <= {root_r[32:0], 1'b1};
      end else begin
        rem_r  <= rem2;
        root_r <= {root_r[32:0], 1'b0};
      end
    end
    if (cmd.mul_load && cmd.mul_sel == pcfs_pkg::SEL_NUM) cube_r <= mp[0];
    if (cmd.emit) begin
      out_r.out_index  <= 6'(idx_i);
      out_r.kick_x     <= kick[0];
      out_r.kick_y     <= kick[1];
      out_r.kick_z     <= kick[2];
      out_r.coincident <= coinc_r;
      out_r.saturated  <= sat[0] | sat[1] | sat[2];
      out_r.is_last    <= cmd.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coinc_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.acc_clr) coinc_r <= 1'b0;
      else if (cmd.sum && s_sum == '0) coinc_r <= 1'b1;
    end
  end

  assign stat.s_zero = (s_r == '0);
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

endmodule

>>> sv/pcfs_ctrl.sv
module pcfs_ctrl #(
  parameter int MAX_PARTICLES = 64,
  parameter int AW            = 6,
  parameter int CW            = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            in_cmd,
  input  logic [5:0]      in_index,
  input  logic [6:0]      particle_count,
  input  pcfs_pkg::stat_t stat,
  output logic            busy,
  output pcfs_pkg::cmd_t  cmd,
  output logic [AW-1:0]   idx_i,
  output logic [AW-1:0]   idx_j
);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_IBEGIN = 15'b000000000000010,
    ST_JCHK   = 15'b000000000000100,
    ST_RD     = 15'b000000000001000,
    ST_DIFF   = 15'b000000000010000,
    ST_SQ     = 15'b000000000100000,
    ST_SUM    = 15'b000000001000000,
    ST_SQRT   = 15'b000000010000000,
    ST_CUBE1  = 15'b000000100000000,
    ST_CUBE2  = 15'b000001000000000,
    ST_NUM    = 15'b000010000000000,
    ST_DIV    = 15'b000100000000000,
    ST_ACC    = 15'b001000000000000,
    ST_FIN    = 15'b010000000000000,
    ST_EMIT   = 15'b100000000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt, i_r, i_nxt, j_r, j_nxt, n_clamp;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          accept;

  assign accept  = start && (state_r == ST_IDLE);
  assign n_clamp = (particle_count > 7'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES)
                                                       : CW'(particle_count);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mul_sel = pcfs_pkg::SEL_SQ;
    cmd.mem_we  = accept && in_cmd == pcfs_pkg::CMD_LOAD &&
                  (7'(in_index) < 7'(MAX_PARTICLES));
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == pcfs_pkg::CMD_COMPUTE && n_clamp != '0) begin
          n_nxt     = n_clamp;
          i_nxt     = '0;
          state_nxt = ST_IBEGIN;
        end
      end
      ST_IBEGIN: begin
        cmd.acc_clr = 1'b1;
        j_nxt       = '0;
        state_nxt   = ST_JCHK;
      end
      ST_JCHK: begin
        priority if (j_r == n_r) state_nxt = ST_FIN;
        else if (j_r == i_r)     j_nxt = j_r + 1'b1;
        else                     state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_load = (cnt_r == '0);
        cmd.sqrt_step = (cnt_r != '0);
        cnt_nxt       = cnt_r + 1'b1;
        priority if (cnt_r == '0 && stat.s_zero) begin
          cnt_nxt   = '0;
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_JCHK;
        end else if (cnt_r == pcfs_pkg::SQRT_STEPS) begin
          cnt_nxt   = '0;
          state_nxt = ST_CUBE1;
        end else begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQ, ST_CUBE1, ST_CUBE2, ST_NUM: begin
        cmd.mul_load = (cnt_r == '0);
        cmd.mul_step = (cnt_r != '0);
        cmd.mul_sel  = (state_r == ST_SQ)    ? pcfs_pkg::SEL_SQ :
                       (state_r == ST_CUBE1) ? pcfs_pkg::SEL_CUBE1 :
                       (state_r == ST_CUBE2) ? pcfs_pkg::SEL_CUBE2 : pcfs_pkg::SEL_NUM;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == pcfs_pkg::MUL_STEPS) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_SQ)    ? ST_SUM :
                      (state_r == ST_CUBE1) ? ST_CUBE2 :
                      (state_r == ST_CUBE2) ? ST_NUM : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_load = (cnt_r == '0);
        cmd.div_step = (cnt_r != '0);
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == pcfs_pkg::DIV_STEPS) begin
          cnt_nxt   = '0;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        j_nxt       = j_r + 1'b1;
        state_nxt   = ST_JCHK;
      end
      ST_FIN: begin
        cmd.fin_shift = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.is_last = (i_r == n_r - 1'b1);
        i_nxt       = i_r + 1'b1;
        state_nxt   = cmd.is_last ? ST_IDLE : ST_IBEGIN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  assign busy  = (state_r != ST_IDLE);
  assign idx_i = i_r[AW-1:0];
  assign idx_j = j_r[AW-1:0];

endmodule

>>> sv/pairwise_coulomb_force_sum.sv
// Channel   Handshake          Payload
// input     start / busy       in_data  (in_beat_t)
// result    out_valid strobe   out_data (out_beat_t)
// config    cfg_we             cfg_index, cfg_wdata
//
// A load beat writes the particle store in its accept cycle; the block stays ready.
// A compute beat works through each ordered pair in turn with the 112-step
// dividers and the four 34-step multiplier passes plus the 34-step square root;
// the block stays busy and takes no new beat until the last result is out.
// Reset is synchronous, active low; the particle store is not cleared.
// Results are one-cycle strobes; the receiver cannot stall.
`include "pairwise_coulomb_force_sum_defines.svh"

module pairwise_coulomb_force_sum #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pcfs_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output pcfs_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  logic [6:0]  count_r;
  logic [31:0] gain_r;
  logic [5:0]  shift_r;

  pcfs_pkg::cmd_t  cmd;
  pcfs_pkg::stat_t stat;
  logic [AW-1:0]   idx_i, idx_j;
  logic            compute_go;

  // configuration registers; writes beyond the last index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 7'd2;
      gain_r  <= 32'd1;
      shift_r <= 6'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcfs_pkg::REG_COUNT: count_r <= cfg_wdata[6:0];
        pcfs_pkg::REG_GAIN:  gain_r  <= cfg_wdata;
        pcfs_pkg::REG_SHIFT: shift_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  pcfs_ctrl #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .AW            (AW),
    .CW            (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_cmd         (in_data.cmd),
    .in_index       (in_data.particle_index),
    .particle_count (count_r),
    .stat           (stat),
    .busy           (busy),
    .cmd            (cmd),
    .idx_i          (idx_i),
    .idx_j          (idx_j)
  );

  pcfs_dp #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .AW            (AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .idx_i     (idx_i),
    .idx_j     (idx_j),
    .cfg_gain  (gain_r),
    .cfg_shift (shift_r),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // accepted compute beat with a non-zero count
  assign compute_go = start && !busy && in_data.cmd == pcfs_pkg::CMD_COMPUTE &&
                      count_r != 7'd0;

  // a non-empty compute beat must leave the controller busy
  `PCFS_ASSERT_NXT(a_compute_busy, compute_go, busy, "compute beat did not start")
  // results come from the emit state, never back to back
  `PCFS_ASSERT_NXT(a_result_gap, out_valid, !out_valid, "results back to back")
  `PCFS_ASSERT_IMP(a_result_busy, out_valid, $past(busy), "result without preceding work")

endmodule
